@@ src/cst_pkg.sv @@
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, character constants and classifier functions for the
// C subset tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

   localparam int NUMBER_WIDTH = 32;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CH_ZERO       = 8'h30;
   localparam logic [7:0] CH_NINE       = 8'h39;
   localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CH_QUOTE      = 8'h27;
   localparam logic [7:0] CH_DQUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH  = 8'h5C;
   localparam logic [7:0] CH_SPACE      = 8'h20;

   typedef enum logic [2:0] {
      TOK_INT    = 3'd0,
      TOK_IDENT  = 3'd1,
      TOK_STRING = 3'd2,
      TOK_CHAR   = 3'd3,
      TOK_PUNCT  = 3'd4,
      TOK_END    = 3'd5,
      TOK_ERROR  = 3'd6
   } token_kind_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_UNEXPECTED   = 3'd1,
      ERR_BAD_CHAR     = 3'd2,
      ERR_UNTERM_CHAR  = 3'd3,
      ERR_UNTERM_STR   = 3'd4,
      ERR_UNTERM_ESC   = 3'd5
   } error_code_type;

   typedef struct packed {
      token_kind_type     kind;
      logic signed [31:0] value;
      logic               first;
      logic               last;
      logic               has_char;
      error_code_type     err;
   } result_type;

   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type res0;
      result_type res1;
   } result_pair_type;

   function automatic result_type make_result(token_kind_type kind,
                                              logic signed [31:0] value,
                                              logic first, logic last,
                                              logic has_char,
                                              error_code_type err);
      result_type r;
      r.kind     = kind;
      r.value    = value;
      r.first    = first;
      r.last     = last;
      r.has_char = has_char;
      r.err      = err;
      return r;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_alpha_us(logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
             (c == CH_UNDERSCORE);
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c >= 8'h09 && c <= 8'h0D);
   endfunction

   function automatic logic is_op_char(logic [7:0] c);
      logic p;
      case (c)
         8'h2F, 8'h3D, 8'h2A, 8'h2B, 8'h2D, 8'h28, 8'h29,
         8'h2C, 8'h3B, 8'h26, 8'h5B, 8'h5D, 8'h7B, 8'h7D: p = 1'b1;
         default:                                          p = 1'b0;
      endcase
      return p;
   endfunction

endpackage

@@ src/cst_stream_if.sv @@
// ----------------------------------------------------------------------------
// cst_req_if / cst_rsp_if
// Valid/ready channels for source bytes and tokens.
// ----------------------------------------------------------------------------
interface cst_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_code;

   modport source (output valid, output kind, output char_code, input ready);
   modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface cst_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         token_kind;
   logic signed [31:0] token_value;
   logic               piece_first;
   logic               piece_last;
   logic               piece_has_char;
   logic [2:0]         error_code;

   modport source (output valid, output token_kind, output token_value,
                   output piece_first, output piece_last, output piece_has_char,
                   output error_code, input ready);
   modport sink   (input valid, input token_kind, input token_value,
                   input piece_first, input piece_last, input piece_has_char,
                   input error_code, output ready);
endinterface

@@ src/cst_lexer.sv @@
// ----------------------------------------------------------------------------
// cst_lexer
// Lexer state and the per-byte step: gives up to two tokens per word.
// ----------------------------------------------------------------------------
module cst_lexer
   import cst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step_valid,
   input  logic            kind,
   input  logic [7:0]      char_code,
   output result_pair_type step_out
);

   typedef enum logic [3:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_IDENT,
      MODE_STR_START,
      MODE_STR,
      MODE_ESC_START,
      MODE_ESC,
      MODE_CHR_OPEN,
      MODE_CHR_ESC,
      MODE_CHR_CLOSE,
      MODE_HALT
   } mode_type;

   mode_type                  mode_ff, mode_in;
   logic [NUMBER_WIDTH-1:0]   acc_ff, acc_in;
   logic [7:0]                held_ff, held_in;

   // byte handled as a token start
   logic                      idle_valid;
   result_type                idle_res;
   mode_type                  idle_mode;
   logic                      idle_load;

   logic                      eof;
   logic signed [31:0]        chr_val;
   logic [NUMBER_WIDTH-1:0]   digit;
   logic [NUMBER_WIDTH-1:0]   acc_next;
   logic signed [31:0]        int_val;

   assign eof      = kind;
   assign chr_val  = {24'd0, char_code};
   assign digit    = NUMBER_WIDTH'(char_code[3:0]);
   assign acc_next = (acc_ff << 3) + (acc_ff << 1) + digit;
   assign int_val  = 32'(signed'(acc_ff));

   always_comb begin
      idle_valid = 1'b0;
      idle_res   = make_result(TOK_END, 32'sd0, 1'b0, 1'b0, 1'b0, ERR_NONE);
      idle_mode  = MODE_IDLE;
      idle_load  = 1'b0;
      if (eof) begin
         idle_valid = 1'b1;
      end else if (is_space(char_code)) begin
         idle_valid = 1'b0;
      end else if (is_digit(char_code)) begin
         idle_load = 1'b1;
         idle_mode = MODE_NUM;
      end else if (is_alpha_us(char_code)) begin
         idle_valid = 1'b1;
         idle_res   = make_result(TOK_IDENT, chr_val, 1'b1, 1'b0, 1'b1, ERR_NONE);
         idle_mode  = MODE_IDENT;
      end else if (char_code == CH_DQUOTE) begin
         idle_mode = MODE_STR_START;
      end else if (char_code == CH_QUOTE) begin
         idle_mode = MODE_CHR_OPEN;
      end else if (is_op_char(char_code)) begin
         idle_valid = 1'b1;
         idle_res   = make_result(TOK_PUNCT, chr_val, 1'b0, 1'b0, 1'b0, ERR_NONE);
      end else begin
         idle_valid = 1'b1;
         idle_res   = make_result(TOK_ERROR, chr_val, 1'b0, 1'b0, 1'b0,
                                  ERR_UNEXPECTED);
         idle_mode  = MODE_HALT;
      end
   end

   always_comb begin
      step_out.valid0 = 1'b0;
      step_out.valid1 = 1'b0;
      step_out.res0   = idle_res;
      step_out.res1   = idle_res;
      mode_in         = mode_ff;
      acc_in          = acc_ff;
      held_in         = held_ff;
      unique case (mode_ff)
         MODE_NUM: begin
            if (!eof && is_digit(char_code)) begin
               acc_in = acc_next;
            end else begin
               step_out.valid0 = 1'b1;
               step_out.res0   = make_result(TOK_INT, int_val, 1'b0, 1'b0, 1'b0,
                                             ERR_NONE);
               step_out.valid1 = idle_valid;
               mode_in         = idle_mode;
               if (idle_load) acc_in = digit;
            end
         end
         MODE_IDENT: begin
            step_out.valid0 = 1'b1;
            if (!eof && (is_alpha_us(char_code) || is_digit(char_code))) begin
               step_out.res0 = make_result(TOK_IDENT, chr_val, 1'b0, 1'b0, 1'b1,
                                           ERR_NONE);
            end else begin
               step_out.res0   = make_result(TOK_IDENT, 32'sd0, 1'b0, 1'b1, 1'b0,
                                             ERR_NONE);
               step_out.valid1 = idle_valid;
               mode_in         = idle_mode;
               if (idle_load) acc_in = digit;
            end
         end
         MODE_STR_START, MODE_STR: begin
            if (eof) begin
               step_out.valid0 = 1'b1;
               step_out.res0   = make_result(TOK_ERROR, 32'sd0, 1'b0, 1'b0, 1'b0,
                                             ERR_UNTERM_STR);
               mode_in         = MODE_HALT;
            end else if (char_code == CH_DQUOTE) begin
               step_out.valid0 = 1'b1;
               step_out.res0   = make_result(TOK_STRING, 32'sd0,
                                             mode_ff == MODE_STR_START, 1'b1, 1'b0,
                                             ERR_NONE);
               mode_in         = MODE_IDLE;
            end else if (char_code == CH_BACKSLASH) begin
               mode_in = (mode_ff == MODE_STR_START) ? MODE_ESC_START : MODE_ESC;
            end else begin
               step_out.valid0 = 1'b1;
               step_out.res0   = make_result(TOK_STRING, chr_val,
                                             mode_ff == MODE_STR_START, 1'b0, 1'b1,
                                             ERR_NONE);
               mode_in         = MODE_STR;
            end
         end
         MODE_ESC_START, MODE_ESC: begin
            step_out.valid0 = 1'b1;
            if (eof) begin
               step_out.res0 = make_result(TOK_ERROR, 32'sd0, 1'b0, 1'b0, 1'b0,
                                           ERR_UNTERM_ESC);
               mode_in       = MODE_HALT;
            end else begin
               step_out.res0 = make_result(TOK_STRING, chr_val,
                                           mode_ff == MODE_ESC_START, 1'b0, 1'b1,
                                           ERR_NONE);
               mode_in       = MODE_STR;
            end
         end
         MODE_CHR_OPEN, MODE_CHR_ESC: begin
            if (eof) begin
               step_out.valid0 = 1'b1;
               step_out.res0   = make_result(TOK_ERROR, 32'sd0, 1'b0, 1'b0, 1'b0,
                                             ERR_UNTERM_CHAR);
               mode_in         = MODE_HALT;
            end else if (mode_ff == MODE_CHR_OPEN && char_code == CH_BACKSLASH) begin
               mode_in = MODE_CHR_ESC;
            end else begin
               held_in = char_code;
               mode_in = MODE_CHR_CLOSE;
            end
         end
         MODE_CHR_CLOSE: begin
            step_out.valid0 = 1'b1;
            if (eof) begin
               step_out.res0 = make_result(TOK_ERROR, 32'sd0, 1'b0, 1'b0, 1'b0,
                                           ERR_UNTERM_CHAR);
               mode_in       = MODE_HALT;
            end else if (char_code == CH_QUOTE) begin
               step_out.res0 = make_result(TOK_CHAR, {24'd0, held_ff}, 1'b0, 1'b0,
                                           1'b0, ERR_NONE);
               mode_in       = MODE_IDLE;
            end else begin
               step_out.res0 = make_result(TOK_ERROR, chr_val, 1'b0, 1'b0, 1'b0,
                                           ERR_BAD_CHAR);
               mode_in       = MODE_HALT;
            end
         end
         MODE_HALT: begin
            mode_in = MODE_HALT;
         end
         default: begin
            step_out.valid0 = idle_valid;
            mode_in         = idle_mode;
            if (idle_load) acc_in = digit;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         acc_ff  <= '0;
         held_ff <= '0;
      end else if (step_valid) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         held_ff <= held_in;
      end
   end

endmodule

@@ src/cst_result_queue.sv @@
// ----------------------------------------------------------------------------
// cst_result_queue
// Small token queue: takes up to two tokens per cycle, hands out one.
// ----------------------------------------------------------------------------
module cst_result_queue
   import cst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  result_pair_type push_data,
   input  logic            pop,
   output logic            has_room,
   output logic            head_valid,
   output result_type      head
);

   result_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]     wr_ff, wr_in;
   logic [QUEUE_PTR_W-1:0]     rd_ff, rd_in;
   logic [QUEUE_PTR_W:0]       count_ff, count_in;
   logic                       wr_a, wr_b;
   result_type                 data_a;
   logic                       do_pop;

   assign has_room   = count_ff <= (QUEUE_PTR_W+1)'(QUEUE_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = entry_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   // pack the tokens of one word into consecutive slots
   assign wr_a   = push && (push_data.valid0 || push_data.valid1);
   assign wr_b   = push && push_data.valid0 && push_data.valid1;
   assign data_a = push_data.valid0 ? push_data.res0 : push_data.res1;

   always_comb begin
      wr_in    = wr_ff + QUEUE_PTR_W'(wr_a) + QUEUE_PTR_W'(wr_b);
      rd_in    = rd_ff + QUEUE_PTR_W'(do_pop);
      count_in = count_ff + (QUEUE_PTR_W+1)'(wr_a) + (QUEUE_PTR_W+1)'(wr_b)
                 - (QUEUE_PTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (wr_a) entry_ff[wr_ff] <= data_a;
      if (wr_b) entry_ff[wr_ff + QUEUE_PTR_W'(1)] <= push_data.res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ src/c_subset_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// c_subset_tokenizer_core
// Byte-serial lexer for a small C subset.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one word per source byte (kind 0) or an end-of-input
//   marker (kind 1). rsp_chan carries one token per transfer: integers,
//   identifier/string pieces with first/last marks, char literals,
//   punctuation, end and error tokens.
//   A byte is accepted every cycle while two queue slots are free; its
//   tokens (zero, one or two) enter a four-entry queue in the same edge and
//   the first one is offered on rsp_chan the next cycle if no older
//   tokens wait. A word that closes a number or an identifier and also
//   gives a token of its own yields two tokens.
//   When the receiver stalls, the queue fills and req_chan.ready drops
//   once fewer than two slots remain.
//   Reset (synchronous) empties the queue and puts the lexer between tokens
//   with a zero accumulator. After an error token the lexer swallows every
//   further byte until reset.
// ----------------------------------------------------------------------------
module c_subset_tokenizer_core
   import cst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   cst_req_if.sink   req_chan,
   cst_rsp_if.source rsp_chan
);

   logic            req_accept;
   logic            room;
   result_pair_type step_out;
   result_type      head;

   assign req_chan.ready = room;
   assign req_accept     = req_chan.valid && room;

   cst_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .step_valid (req_accept),
      .kind       (req_chan.kind),
      .char_code  (req_chan.char_code),
      .step_out   (step_out)
   );

   cst_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_accept),
      .push_data  (step_out),
      .pop        (rsp_chan.ready),
      .has_room   (room),
      .head_valid (rsp_chan.valid),
      .head       (head)
   );

   assign rsp_chan.token_kind     = head.kind;
   assign rsp_chan.token_value    = head.value;
   assign rsp_chan.piece_first    = head.first;
   assign rsp_chan.piece_last     = head.last;
   assign rsp_chan.piece_has_char = head.has_char;
   assign rsp_chan.error_code     = head.err;

endmodule

@@ tb/c_subset_tokenizer_core_test.sv @@
// ----------------------------------------------------------------------------
// c_subset_tokenizer_core_test
// Self-checking bench for the byte-serial C subset lexer. A directed table of
// source words (some with typed-in tokens) is followed by random well-formed
// token streams with random content. A single error sequence closes the run,
// since an error halts the lexer until reset. Every word accepted goes
// through a local lexer model, and each token that comes out is checked
// against the oldest expected token.
// ----------------------------------------------------------------------------
module c_subset_tokenizer_core_test;
   import cst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic K_BYTE = 1'b0;
   localparam logic K_EOF  = 1'b1;
   localparam int   PREDICT = -1;

   localparam int RANDOM_WORDS = 1150;
   localparam int DRAIN_AT     = 600;
   localparam int HOLD_START   = 400;
   localparam int HOLD_END     = 600;
   localparam int CALM_START   = 800;
   localparam int CALM_END     = 1100;
   localparam int IDLE_PCT     = 6;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int TAIL_CYCLES  = 20;

   localparam string BLANKS     = "\t\n\v\f\r ";
   localparam string PUNCT_SET  = "/=*+-(),;&[]{}";
   localparam string WORD_CHARS =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   localparam int    WORD_START_N = 53;

   typedef enum logic [3:0] {
      ST_IDLE, ST_NUMBER, ST_IDENT, ST_STR_OPEN, ST_STR, ST_ESC_OPEN, ST_ESC,
      ST_CHR_OPEN, ST_CHR_ESC, ST_CHR_CLOSE, ST_HALTED
   } lex_state_type;

   typedef struct {
      logic       kind;
      logic [7:0] code;
      int         n_typed;
      result_type t0;
      result_type t1;
      bit         drain_first;
   } src_word_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cst_req_if req_chan();
   cst_rsp_if rsp_chan();

   c_subset_tokenizer_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   src_word_t  src_words[$];
   src_word_t  dir_table[$];
   result_type pending_tokens[$];
   result_type step_tokens[$];
   int         send_idx    = 0;
   int         cycle_count = 0;
   int         rx_cycles   = 0;
   int         fail_count  = 0;
   int         random_words = 0;
   bit         drain_next  = 0;

   lex_state_type          lex_state = ST_IDLE;
   logic [NUMBER_WIDTH-1:0] num_acc  = '0;
   logic [7:0]             held_byte = '0;

   // ---------------------------------------------------------------- classes
   function automatic bit in_set(logic [7:0] c, string set);
      for (int i = 0; i < set.len(); i++)
         if (set[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit is_dec(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit is_word_start(logic [7:0] c);
      return in_set(c, WORD_CHARS.substr(0, WORD_START_N - 1));
   endfunction

   function automatic bit is_stray(logic [7:0] c);
      return !(in_set(c, BLANKS) || is_dec(c) || is_word_start(c) ||
               c == CH_QUOTE || c == CH_DQUOTE || in_set(c, PUNCT_SET));
   endfunction

   function automatic result_type tok(token_kind_type k, logic signed [31:0] v,
                                      logic f, logic l, logic h,
                                      error_code_type e);
      result_type r;
      r.kind = k; r.value = v; r.first = f; r.last = l; r.has_char = h;
      r.err = e;
      return r;
   endfunction

   function automatic logic signed [31:0] chv(logic [7:0] c);
      return {24'd0, c};
   endfunction

   // --------------------------------------------------------------- lexer model
   task automatic halt_with(error_code_type e, logic [7:0] c);
      step_tokens.push_back(tok(TOK_ERROR, chv(c), 0, 0, 0, e));
      lex_state = ST_HALTED;
   endtask

   task automatic lex_step(logic eof, logic [7:0] c);
      bit again;
      bit opening;
      again = 1'b1;
      while (again) begin
         again = 1'b0;
         opening = (lex_state == ST_STR_OPEN) || (lex_state == ST_ESC_OPEN);
         case (lex_state)
            ST_NUMBER: begin
               if (!eof && is_dec(c)) begin
                  num_acc = num_acc * 4'd10 + c - CH_ZERO;
               end else begin
                  step_tokens.push_back(tok(TOK_INT, 32'($signed(num_acc)),
                                            0, 0, 0, ERR_NONE));
                  lex_state = ST_IDLE;
                  again = 1'b1;
               end
            end
            ST_IDENT: begin
               if (!eof && (is_word_start(c) || is_dec(c))) begin
                  step_tokens.push_back(tok(TOK_IDENT, chv(c), 0, 0, 1, ERR_NONE));
               end else begin
                  step_tokens.push_back(tok(TOK_IDENT, 0, 0, 1, 0, ERR_NONE));
                  lex_state = ST_IDLE;
                  again = 1'b1;
               end
            end
            ST_STR_OPEN, ST_STR: begin
               if (eof) begin
                  halt_with(ERR_UNTERM_STR, 8'd0);
               end else if (c == CH_DQUOTE) begin
                  step_tokens.push_back(tok(TOK_STRING, 0, opening, 1, 0, ERR_NONE));
                  lex_state = ST_IDLE;
               end else if (c == CH_BACKSLASH) begin
                  lex_state = opening ? ST_ESC_OPEN : ST_ESC;
               end else begin
                  step_tokens.push_back(tok(TOK_STRING, chv(c), opening, 0, 1,
                                            ERR_NONE));
                  lex_state = ST_STR;
               end
            end
            ST_ESC_OPEN, ST_ESC: begin
               if (eof) begin
                  halt_with(ERR_UNTERM_ESC, 8'd0);
               end else begin
                  step_tokens.push_back(tok(TOK_STRING, chv(c), opening, 0, 1,
                                            ERR_NONE));
                  lex_state = ST_STR;
               end
            end
            ST_CHR_OPEN, ST_CHR_ESC: begin
               if (eof) begin
                  halt_with(ERR_UNTERM_CHAR, 8'd0);
               end else if (lex_state == ST_CHR_OPEN && c == CH_BACKSLASH) begin
                  lex_state = ST_CHR_ESC;
               end else begin
                  held_byte = c;
                  lex_state = ST_CHR_CLOSE;
               end
            end
            ST_CHR_CLOSE: begin
               if (eof) begin
                  halt_with(ERR_UNTERM_CHAR, 8'd0);
               end else if (c == CH_QUOTE) begin
                  step_tokens.push_back(tok(TOK_CHAR, chv(held_byte), 0, 0, 0,
                                            ERR_NONE));
                  lex_state = ST_IDLE;
               end else begin
                  halt_with(ERR_BAD_CHAR, c);
               end
            end
            ST_HALTED: begin
            end
            default: begin
               lex_state = ST_IDLE;
               if (eof) begin
                  step_tokens.push_back(tok(TOK_END, 0, 0, 0, 0, ERR_NONE));
               end else if (in_set(c, BLANKS)) begin
               end else if (is_dec(c)) begin
                  num_acc = c - CH_ZERO;
                  lex_state = ST_NUMBER;
               end else if (is_word_start(c)) begin
                  step_tokens.push_back(tok(TOK_IDENT, chv(c), 1, 0, 1, ERR_NONE));
                  lex_state = ST_IDENT;
               end else if (c == CH_DQUOTE) begin
                  lex_state = ST_STR_OPEN;
               end else if (c == CH_QUOTE) begin
                  lex_state = ST_CHR_OPEN;
               end else if (in_set(c, PUNCT_SET)) begin
                  step_tokens.push_back(tok(TOK_PUNCT, chv(c), 0, 0, 0, ERR_NONE));
               end else begin
                  halt_with(ERR_UNEXPECTED, c);
               end
            end
         endcase
      end
   endtask

   // typed-in tokens stand in for the model output on directed rows that give them
   task automatic expect_tokens(src_word_t w);
      step_tokens.delete();
      lex_step(w.kind, w.code);
      if (w.n_typed == PREDICT) begin
         foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
      end else begin
         if (w.n_typed > 0) pending_tokens.push_back(w.t0);
         if (w.n_typed > 1) pending_tokens.push_back(w.t1);
      end
   endtask

   // ---------------------------------------------------------------- checking
   task automatic report(string msg);
      fail_count++;
      if (fail_count <= 40) $display("MISMATCH cycle %0d: %s", cycle_count, msg);
   endtask

   task automatic check_token();
      result_type want;
      if (pending_tokens.size() == 0) begin
         report($sformatf("token kind %0d value %0d with nothing expected",
                          rsp_chan.token_kind, rsp_chan.token_value));
         return;
      end
      want = pending_tokens.pop_front();
      if (rsp_chan.token_kind !== want.kind)
         report($sformatf("token_kind %0d, expected %0d",
                          rsp_chan.token_kind, want.kind));
      if (rsp_chan.token_value !== want.value)
         report($sformatf("token_value %0d, expected %0d",
                          rsp_chan.token_value, want.value));
      if (rsp_chan.piece_first !== want.first)
         report($sformatf("piece_first %b, expected %b",
                          rsp_chan.piece_first, want.first));
      if (rsp_chan.piece_last !== want.last)
         report($sformatf("piece_last %b, expected %b",
                          rsp_chan.piece_last, want.last));
      if (rsp_chan.piece_has_char !== want.has_char)
         report($sformatf("piece_has_char %b, expected %b",
                          rsp_chan.piece_has_char, want.has_char));
      if (rsp_chan.error_code !== want.err)
         report($sformatf("error_code %0d, expected %0d",
                          rsp_chan.error_code, want.err));
   endtask

   // --------------------------------------------------------------- stimulus
   function automatic src_word_t row(logic k, logic [7:0] c, int n = PREDICT,
                                     result_type t0 = '0, result_type t1 = '0);
      src_word_t w;
      w.kind = k; w.code = c; w.n_typed = n; w.t0 = t0; w.t1 = t1;
      w.drain_first = 1'b0;
      return w;
   endfunction

   task automatic push_word(logic k, logic [7:0] c);
      src_word_t w;
      w = row(k, c);
      w.drain_first = drain_next;
      drain_next = 1'b0;
      src_words.push_back(w);
      random_words++;
      if (random_words == DRAIN_AT) drain_next = 1'b1;
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) push_word(K_BYTE, s[i]);
   endtask

   function automatic logic [7:0] pick(string set, int n);
      return set[$urandom_range(n - 1)];
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = $urandom_range(255);
      while (b == CH_BACKSLASH || b == CH_DQUOTE) b = $urandom_range(255);
      return b;
   endfunction

   task automatic gen_fragment();
      int sel;
      int len;
      sel = $urandom_range(99);
      if (sel < 18) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(4, 1);
         case ($urandom_range(29))
            0:       push_text("4294967295");
            1:       push_text("4294967296");
            2:       push_text("2147483648");
            default: for (int i = 0; i < len; i++) push_word(K_BYTE, pick("0123456789", 10));
         endcase
         if ($urandom_range(9) < 3) push_word(K_EOF, $urandom_range(255));
      end else if (sel < 36) begin
         push_word(K_BYTE, pick(WORD_CHARS, WORD_START_N));
         len = $urandom_range(5);
         for (int i = 0; i < len; i++) push_word(K_BYTE, pick(WORD_CHARS, WORD_CHARS.len()));
         if ($urandom_range(4) == 0) push_word(K_EOF, $urandom_range(255));
      end else if (sel < 54) begin
         push_word(K_BYTE, CH_DQUOTE);
         len = $urandom_range(6);
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(4) == 0) begin
               push_word(K_BYTE, CH_BACKSLASH);
               push_word(K_BYTE, $urandom_range(255));
            end else begin
               push_word(K_BYTE, plain_byte());
            end
         end
         push_word(K_BYTE, CH_DQUOTE);
      end else if (sel < 66) begin
         push_word(K_BYTE, CH_QUOTE);
         if ($urandom_range(3) == 0) begin
            push_word(K_BYTE, CH_BACKSLASH);
            push_word(K_BYTE, $urandom_range(255));
         end else begin
            push_word(K_BYTE, ($urandom_range(1) == 0) ? plain_byte() : CH_DQUOTE);
         end
         push_word(K_BYTE, CH_QUOTE);
      end else if (sel < 80) begin
         push_word(K_BYTE, pick(PUNCT_SET, PUNCT_SET.len()));
      end else if (sel < 94) begin
         len = $urandom_range(3, 1);
         for (int i = 0; i < len; i++) push_word(K_BYTE, pick(BLANKS, BLANKS.len()));
      end else begin
         push_word(K_EOF, $urandom_range(255));
      end
   endtask

   // one error ends the run: the lexer stays halted until reset
   task automatic gen_error_tail();
      logic [7:0] b;
      case ($urandom_range(ERR_UNTERM_ESC, ERR_UNEXPECTED))
         ERR_UNEXPECTED: begin
            b = $urandom_range(255);
            while (!is_stray(b)) b = $urandom_range(255);
            push_word(K_BYTE, b);
         end
         ERR_BAD_CHAR: begin
            push_word(K_BYTE, CH_QUOTE);
            push_word(K_BYTE, plain_byte());
            b = $urandom_range(255);
            while (b == CH_QUOTE) b = $urandom_range(255);
            push_word(K_BYTE, b);
         end
         ERR_UNTERM_CHAR: begin
            push_word(K_BYTE, CH_QUOTE);
            case ($urandom_range(2))
               0: ;
               1: push_word(K_BYTE, plain_byte());
               default: push_word(K_BYTE, CH_BACKSLASH);
            endcase
            push_word(K_EOF, $urandom_range(255));
         end
         ERR_UNTERM_STR: begin
            push_word(K_BYTE, CH_DQUOTE);
            push_word(K_BYTE, plain_byte());
            push_word(K_EOF, $urandom_range(255));
         end
         default: begin
            push_word(K_BYTE, CH_DQUOTE);
            if ($urandom_range(1) == 0) push_word(K_BYTE, plain_byte());
            push_word(K_BYTE, CH_BACKSLASH);
            push_word(K_EOF, $urandom_range(255));
         end
      endcase
      for (int i = 0; i < 8; i++) push_word($urandom_range(1), $urandom_range(255));
   endtask

   task automatic build_stimulus();
      dir_table = '{
         row(K_EOF,  8'h00, 1, tok(TOK_END, 0, 0, 0, 0, ERR_NONE)),
         row(K_EOF,  8'hFF, 1, tok(TOK_END, 0, 0, 0, 0, ERR_NONE)),
         row(K_BYTE, CH_SPACE, 0),
         row(K_BYTE, 8'h09),
         row(K_BYTE, 8'h0D),
         row(K_BYTE, "9"),
         row(K_BYTE, "0"),
         row(K_BYTE, "}", 2, tok(TOK_INT, 90, 0, 0, 0, ERR_NONE),
             tok(TOK_PUNCT, chv("}"), 0, 0, 0, ERR_NONE)),
         row(K_BYTE, "_"),
         row(K_BYTE, "z"),
         row(K_BYTE, "0"),
         row(K_EOF,  8'h00, 2, tok(TOK_IDENT, 0, 0, 1, 0, ERR_NONE),
             tok(TOK_END, 0, 0, 0, 0, ERR_NONE)),
         row(K_BYTE, CH_DQUOTE),
         row(K_BYTE, CH_DQUOTE, 1, tok(TOK_STRING, 0, 1, 1, 0, ERR_NONE)),
         row(K_BYTE, CH_DQUOTE),
         row(K_BYTE, CH_BACKSLASH),
         row(K_BYTE, 8'hFF, 1, tok(TOK_STRING, 255, 1, 0, 1, ERR_NONE)),
         row(K_BYTE, 8'h00),
         row(K_BYTE, CH_DQUOTE, 1, tok(TOK_STRING, 0, 0, 1, 0, ERR_NONE)),
         row(K_BYTE, CH_QUOTE),
         row(K_BYTE, CH_BACKSLASH),
         row(K_BYTE, CH_QUOTE),
         row(K_BYTE, CH_QUOTE, 1, tok(TOK_CHAR, chv(CH_QUOTE), 0, 0, 0, ERR_NONE)),
         row(K_BYTE, CH_QUOTE),
         row(K_BYTE, 8'h80),
         row(K_BYTE, CH_QUOTE, 1, tok(TOK_CHAR, 128, 0, 0, 0, ERR_NONE)),
         row(K_BYTE, "A"),
         row(K_BYTE, "/", 2, tok(TOK_IDENT, 0, 0, 1, 0, ERR_NONE),
             tok(TOK_PUNCT, chv("/"), 0, 0, 0, ERR_NONE))
      };
      foreach (dir_table[i]) src_words.push_back(dir_table[i]);
      // random part starts from an empty pipe
      drain_next = 1'b1;
      while (random_words < RANDOM_WORDS) gen_fragment();
      gen_error_tail();
   endtask

   // ------------------------------------------------------- driving / checking
   initial begin
      req_chan.valid     = 1'b0;
      req_chan.kind      = K_BYTE;
      req_chan.char_code = 8'h00;
      rsp_chan.ready     = 1'b0;
   end

   always @(posedge clock) begin : source_side
      bit offer;
      bit calm;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         cycle_count++;
         calm = cycle_count >= CALM_START && cycle_count < CALM_END;
         if (rsp_chan.valid && rsp_chan.ready) check_token();
         if (req_chan.valid && req_chan.ready) begin
            expect_tokens(src_words[send_idx]);
            send_idx++;
         end
         // a word on offer stays on offer until taken
         offer = req_chan.valid && !req_chan.ready;
         if (!offer && send_idx < src_words.size()) begin
            if (src_words[send_idx].drain_first && pending_tokens.size() != 0)
               offer = 1'b0;
            else
               offer = calm || $urandom_range(99) >= IDLE_PCT;
         end
         req_chan.valid <= offer;
         if (offer) begin
            req_chan.kind      <= src_words[send_idx].kind;
            req_chan.char_code <= src_words[send_idx].code;
         end
      end
   end

   // sink pacing: random ready, one long hold-off so the token queue fills and backs up, and a calm window
   always @(posedge clock) begin : sink_side
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rx_cycles++;
         if (rx_cycles >= HOLD_START && rx_cycles < HOLD_END)
            rsp_chan.ready <= 1'b0;
         else if (rx_cycles >= CALM_START && rx_cycles < CALM_END)
            rsp_chan.ready <= 1'b1;
         else
            rsp_chan.ready <= $urandom_range(99) >= IDLE_PCT;
      end
   end

   initial begin
      build_stimulus();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      while (send_idx < src_words.size() || pending_tokens.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("c_subset_tokenizer_core regression: pass");
      else
         $display("c_subset_tokenizer_core regression: fail");
      $finish;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TIMEOUT after %0d cycles", CYCLE_LIMIT);
      $display("c_subset_tokenizer_core regression: fail");
      $finish;
   end

endmodule

@@ c_subset_tokenizer_core.f @@
src/cst_pkg.sv
src/cst_stream_if.sv
src/cst_lexer.sv
src/cst_result_queue.sv
src/c_subset_tokenizer_core.sv
tb/c_subset_tokenizer_core_test.sv
